FILE: hw/rtl/r2h_pkg.sv
// Types and constants shared by the RGB to HSV converter.
package r2h_pkg;

	localparam int CH_W = 8;
	localparam int HUE_W = 15;
	localparam int SAT_W = 13;
	localparam int SAT_FRAC = 12;
	localparam int SEC_W = 11;
	localparam int HNUM_W = CH_W + HUE_W;

	localparam logic [HNUM_W-1:0] HUE_PER_SECTOR = HNUM_W'(3840);
	localparam logic [HUE_W-1:0] HUE_PER_TURN = HUE_W'(23040);
	localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(4096);

	localparam logic [SEC_W-1:0] SEC_OFF_RED_WRAP = SEC_W'(6);
	localparam logic [SEC_W-1:0] SEC_OFF_GREEN = SEC_W'(2);
	localparam logic [SEC_W-1:0] SEC_OFF_BLUE = SEC_W'(4);

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} max_sel_t;

endpackage

FILE: hw/rtl/r2h_div.sv
// Pipelined restoring divider, up to ceil(Q_W / STAGES) quotient bits per stage.
module r2h_div #(
	parameter int DEN_W = 8,
	parameter int Q_W = 15,
	parameter int STAGES = 4
) (
	input  logic                   clk,
	input  logic [STAGES-1:0]      en,
	input  logic [DEN_W+Q_W-1:0]   num,
	input  logic [DEN_W-1:0]       den,
	output logic [Q_W-1:0]         quo
);

	localparam int STEPS = (Q_W + STAGES - 1) / STAGES;

	logic [DEN_W-1:0] rem_s  [STAGES];
	logic [Q_W-1:0]   work_s [STAGES];
	logic [DEN_W-1:0] den_s  [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [Q_W-1:0]   work_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W-1:0] rem_nx;
		logic [Q_W-1:0]   work_nx;

		if (k == 0) begin : g_first
			assign rem_in  = num[DEN_W+Q_W-1:Q_W];
			assign work_in = num[Q_W-1:0];
			assign den_in  = den;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign work_in = work_s[k-1];
			assign den_in  = den_s[k-1];
		end

		always_comb begin
			logic [DEN_W:0]   t;
			logic             ge;
			logic [DEN_W-1:0] r;
			logic [Q_W-1:0]   w;
			r = rem_in;
			w = work_in;
			t = '0;
			ge = 1'b0;
			for (int j = 0; j < STEPS; j++) begin
				if (k * STEPS + j < Q_W) begin
					t = {r, w[Q_W-1]};
					ge = (t >= {1'b0, den_in});
					w = {w[Q_W-2:0], ge};
					r = ge ? DEN_W'(t - {1'b0, den_in}) : t[DEN_W-1:0];
				end
			end
			rem_nx = r;
			work_nx = w;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= rem_nx;
				work_s[k] <= work_nx;
				den_s[k]  <= den_in;
			end
		end
	end

	assign quo = work_s[STAGES-1];

endmodule

FILE: hw/rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV pixel converter.
// Takes one pixel per clock while pixel_stall is low and returns one HSV result per pixel, in
// order, through DIV_STAGES + 3 register stages. Two pipelined dividers, one for hue and one
// for saturation, each resolve their quotient over DIV_STAGES register stages; max/min
// selection, sector numerator and hue wrap take one stage each. A stall on the result side
// holds only the stages that are full, so empty stages keep taking pixels. Hue is in 1/64
// degree, saturation is scaled by 4096, brightness is the largest channel; a black pixel
// gives all zeros with hue_undefined set.
module rgb_to_hsv_converter #(
	parameter int DIV_STAGES = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pixel_valid,
	output logic                       pixel_stall,
	input  logic [r2h_pkg::CH_W-1:0]   red,
	input  logic [r2h_pkg::CH_W-1:0]   green,
	input  logic [r2h_pkg::CH_W-1:0]   blue,
	output logic                       hsv_valid,
	input  logic                       hsv_stall,
	output logic [r2h_pkg::HUE_W-1:0]  hue,
	output logic [r2h_pkg::SAT_W-1:0]  saturation,
	output logic [r2h_pkg::CH_W-1:0]   brightness,
	output logic                       hue_undefined
);

	localparam int NSTG = DIV_STAGES + 3;
	localparam int DIV0 = 2;

	logic [NSTG-1:0] vld_s;
	logic [NSTG-1:0] vld_in;
	logic [NSTG:0]   rdy;

	assign vld_in = {vld_s[NSTG-2:0], pixel_valid};

	always_comb begin
		rdy[NSTG] = !hsv_stall;
		for (int i = NSTG - 1; i >= 0; i--) begin
			rdy[i] = !vld_s[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (rdy[i]) begin
					vld_s[i] <= vld_in[i];
				end
			end
		end
	end

	assign pixel_stall = !rdy[0];
	assign hsv_valid = vld_s[NSTG-1];

	// stage 1: largest and smallest channel
	logic [r2h_pkg::CH_W-1:0] red_s1, green_s1, blue_s1, max_s1, min_s1;
	r2h_pkg::max_sel_t        sel_s1;
	logic [r2h_pkg::CH_W-1:0] max_c, min_c;
	r2h_pkg::max_sel_t        sel_c;

	always_comb begin
		priority if (red >= green && red >= blue) begin
			sel_c = r2h_pkg::SEL_RED;
			max_c = red;
		end else if (green >= blue) begin
			sel_c = r2h_pkg::SEL_GREEN;
			max_c = green;
		end else begin
			sel_c = r2h_pkg::SEL_BLUE;
			max_c = blue;
		end
		min_c = red;
		if (green < min_c) min_c = green;
		if (blue < min_c) min_c = blue;
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			max_s1   <= max_c;
			min_s1   <= min_c;
			sel_s1   <= sel_c;
		end
	end

	// stage 2: spread and sector numerator
	logic [r2h_pkg::CH_W-1:0]   delta_c;
	logic [r2h_pkg::SEC_W-1:0]  sec_c, off_c, add_c, sub_c;
	logic [r2h_pkg::CH_W-1:0]   delta_s2, max_s2;
	logic [r2h_pkg::HNUM_W-1:0] hnum_s2;
	logic                       black_s2, gray_s2;

	always_comb begin
		delta_c = max_s1 - min_s1;
		unique case (sel_s1)
			r2h_pkg::SEL_RED: begin
				off_c = (green_s1 >= blue_s1) ? '0 : r2h_pkg::SEC_OFF_RED_WRAP;
				add_c = r2h_pkg::SEC_W'(green_s1);
				sub_c = r2h_pkg::SEC_W'(blue_s1);
			end
			r2h_pkg::SEL_GREEN: begin
				off_c = r2h_pkg::SEC_OFF_GREEN;
				add_c = r2h_pkg::SEC_W'(blue_s1);
				sub_c = r2h_pkg::SEC_W'(red_s1);
			end
			r2h_pkg::SEL_BLUE: begin
				off_c = r2h_pkg::SEC_OFF_BLUE;
				add_c = r2h_pkg::SEC_W'(red_s1);
				sub_c = r2h_pkg::SEC_W'(green_s1);
			end
			default: begin
				off_c = '0;
				add_c = '0;
				sub_c = '0;
			end
		endcase
		sec_c = r2h_pkg::SEC_W'(off_c * r2h_pkg::SEC_W'(delta_c) + add_c - sub_c);
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			delta_s2 <= delta_c;
			max_s2   <= max_s1;
			hnum_s2  <= r2h_pkg::HNUM_W'(sec_c) * r2h_pkg::HUE_PER_SECTOR;
			black_s2 <= (max_s1 == '0);
			gray_s2  <= (delta_c == '0);
		end
	end

	// divider stages
	logic [r2h_pkg::HUE_W-1:0] hue_quo;
	logic [r2h_pkg::SAT_W-1:0] sat_quo;

	r2h_div #(
		.DEN_W  (r2h_pkg::CH_W),
		.Q_W    (r2h_pkg::HUE_W),
		.STAGES (DIV_STAGES)
	) u_hue_div (
		.clk (clk),
		.en  (rdy[DIV0 +: DIV_STAGES]),
		.num (hnum_s2),
		.den (delta_s2),
		.quo (hue_quo)
	);

	r2h_div #(
		.DEN_W  (r2h_pkg::CH_W),
		.Q_W    (r2h_pkg::SAT_W),
		.STAGES (DIV_STAGES)
	) u_sat_div (
		.clk (clk),
		.en  (rdy[DIV0 +: DIV_STAGES]),
		.num ({1'b0, delta_s2, {r2h_pkg::SAT_FRAC{1'b0}}}),
		.den (max_s2),
		.quo (sat_quo)
	);

	logic [r2h_pkg::CH_W-1:0] bright_sd [DIV_STAGES];
	logic                     black_sd  [DIV_STAGES];
	logic                     gray_sd   [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
		logic [r2h_pkg::CH_W-1:0] bright_in;
		logic                     black_in;
		logic                     gray_in;

		if (k == 0) begin : g_first
			assign bright_in = max_s2;
			assign black_in  = black_s2;
			assign gray_in   = gray_s2;
		end else begin : g_next
			assign bright_in = bright_sd[k-1];
			assign black_in  = black_sd[k-1];
			assign gray_in   = gray_sd[k-1];
		end

		always_ff @(posedge clk) begin
			if (rdy[DIV0+k]) begin
				bright_sd[k] <= bright_in;
				black_sd[k]  <= black_in;
				gray_sd[k]   <= gray_in;
			end
		end
	end

	// output stage: wrap hue, zero the special cases
	always_ff @(posedge clk) begin
		if (rdy[NSTG-1]) begin
			if (gray_sd[DIV_STAGES-1]) begin
				hue <= '0;
			end else if (hue_quo >= r2h_pkg::HUE_PER_TURN) begin
				hue <= hue_quo - r2h_pkg::HUE_PER_TURN;
			end else begin
				hue <= hue_quo;
			end
			saturation    <= black_sd[DIV_STAGES-1] ? '0 : sat_quo;
			brightness    <= bright_sd[DIV_STAGES-1];
			hue_undefined <= black_sd[DIV_STAGES-1];
		end
	end

	a_black_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hue_undefined |-> hue == '0 && saturation == '0 && brightness == '0)
		else $error("black pixel result not all zero");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> saturation <= r2h_pkg::SAT_ONE)
		else $error("saturation above one");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue < r2h_pkg::HUE_PER_TURN)
		else $error("hue not wrapped");

	a_gray_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation == '0 |-> hue == '0)
		else $error("hue nonzero for gray pixel");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> hsv_valid && hsv_stall)
		else $error("input stalled while result side free");

endmodule
